// ===== design/biphase_mark_frame_transmitter_defines.svh =====
// ---------------------------------------------------------------------------
// Biphase-mark frame transmitter assertion macros
// Shared property templates for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef BIPHASE_MARK_FRAME_TRANSMITTER_DEFINES_SVH
`define BIPHASE_MARK_FRAME_TRANSMITTER_DEFINES_SVH

// same-cycle implication
`define BMFT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bmft same-cycle check failed");

// next-cycle implication
`define BMFT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bmft next-cycle check failed");

`endif

// ===== design/bmft_pkg.sv =====
// ---------------------------------------------------------------------------
// Biphase-mark frame transmitter package
// Command and result word types, frame phases and timing constants.
// ---------------------------------------------------------------------------
package bmft_pkg;

  typedef enum logic {
    CMD_SEND = 1'b0,
    CMD_TICK = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic line_level;
    logic busy;
    logic pending;
  } res_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_BIT_A = 3'd2,
    PH_BIT_B = 3'd3,
    PH_PAR_A = 3'd4,
    PH_PAR_B = 3'd5,
    PH_STOP  = 3'd6
  } phase_t;

  localparam logic [2:0] START_TICKS = 3'd5;
  localparam logic [2:0] STOP_TICKS  = 3'd6;

endpackage

// ===== design/bmft_queue.sv =====
// ---------------------------------------------------------------------------
// Biphase-mark frame transmitter word queue
// Small register FIFO with push/full and pop/empty sides.
// ---------------------------------------------------------------------------
module bmft_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== design/bmft_front.sv =====
// ---------------------------------------------------------------------------
// Biphase-mark frame transmitter front end
// Accepts input words, classifies them as send or tick, queues commands.
// ---------------------------------------------------------------------------
module bmft_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  logic          in_opcode,
  input  logic [7:0]    in_send_data,
  output logic          cmd_valid,
  output bmft_pkg::cmd_t cmd,
  input  logic          cmd_pop
);

  bmft_pkg::cmd_t cmd_in;
  logic           cmd_empty;
  logic [$bits(bmft_pkg::cmd_t)-1:0] cmd_bits;

  always_comb begin
    cmd_in.kind = in_opcode ? bmft_pkg::CMD_TICK : bmft_pkg::CMD_SEND;
    cmd_in.data = in_send_data;
  end

  bmft_queue #(
    .WIDTH ($bits(bmft_pkg::cmd_t)),
    .DEPTH (2)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (cmd_in),
    .full  (in_full),
    .pop   (cmd_pop),
    .rdata (cmd_bits),
    .empty (cmd_empty)
  );

  assign cmd       = bmft_pkg::cmd_t'(cmd_bits);
  assign cmd_valid = !cmd_empty;

endmodule

// ===== design/bmft_back.sv =====
// ---------------------------------------------------------------------------
// Biphase-mark frame transmitter back end
// Runs the frame FSM one command per cycle unless res_full; queues results.
// ---------------------------------------------------------------------------
module bmft_back #(
  parameter int DATA_BITS = 6
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  bmft_pkg::cmd_t cmd,
  output logic           cmd_pop,
  input  logic           out_pop,
  output logic           out_empty,
  output bmft_pkg::res_t res
);

  bmft_pkg::phase_t phase_r, phase_nxt;
  logic [2:0] tick_left_r, tick_left_nxt;
  logic [2:0] bit_index_r, bit_index_nxt;
  logic [7:0] frame_byte_r, frame_byte_nxt;
  logic       parity_r, parity_nxt;
  logic       pin_r, pin_nxt;
  logic       pend_r, pend_nxt;
  logic [7:0] pend_byte_r, pend_byte_nxt;
  logic       res_full;
  bmft_pkg::res_t res_in;
  logic [$bits(bmft_pkg::res_t)-1:0] res_bits;

  assign cmd_pop = cmd_valid && !res_full;

  always_comb begin
    phase_nxt      = phase_r;
    tick_left_nxt  = tick_left_r;
    bit_index_nxt  = bit_index_r;
    frame_byte_nxt = frame_byte_r;
    parity_nxt     = parity_r;
    pin_nxt        = pin_r;
    pend_nxt       = pend_r;
    pend_byte_nxt  = pend_byte_r;
    if (cmd.kind == bmft_pkg::CMD_SEND) begin
      pend_byte_nxt = cmd.data;
      pend_nxt      = 1'b1;
    end else begin
      case (phase_r)
        bmft_pkg::PH_START: begin
          pin_nxt       = 1'b1;
          tick_left_nxt = tick_left_r - 1'b1;
          if (tick_left_nxt == '0) begin
            pin_nxt   = 1'b0;
            phase_nxt = bmft_pkg::PH_BIT_A;
          end
        end
        bmft_pkg::PH_BIT_A: begin
          pin_nxt   = pin_r ^ frame_byte_r[bit_index_r];
          phase_nxt = bmft_pkg::PH_BIT_B;
        end
        bmft_pkg::PH_BIT_B: begin
          pin_nxt = !pin_r;
          if (bit_index_r == '0) begin
            phase_nxt = bmft_pkg::PH_PAR_A;
          end else begin
            bit_index_nxt = bit_index_r - 1'b1;
            phase_nxt     = bmft_pkg::PH_BIT_A;
          end
        end
        bmft_pkg::PH_PAR_A: begin
          pin_nxt   = pin_r ^ parity_r;
          phase_nxt = bmft_pkg::PH_PAR_B;
        end
        bmft_pkg::PH_PAR_B: begin
          pin_nxt       = !pin_r;
          phase_nxt     = bmft_pkg::PH_STOP;
          tick_left_nxt = bmft_pkg::STOP_TICKS;
        end
        bmft_pkg::PH_STOP: begin
          pin_nxt       = 1'b0;
          tick_left_nxt = tick_left_r - 1'b1;
          if (tick_left_nxt == '0) begin
            phase_nxt = bmft_pkg::PH_IDLE;
          end
        end
        default: begin
        end
      endcase
    end
    if (phase_nxt == bmft_pkg::PH_IDLE && pend_nxt) begin
      pend_nxt       = 1'b0;
      frame_byte_nxt = pend_byte_nxt;
      phase_nxt      = bmft_pkg::PH_START;
      tick_left_nxt  = bmft_pkg::START_TICKS;
      bit_index_nxt  = 3'(DATA_BITS - 1);
      parity_nxt     = ^pend_byte_nxt;
    end
    res_in.line_level = pin_nxt;
    res_in.busy       = (phase_nxt != bmft_pkg::PH_IDLE);
    res_in.pending    = pend_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= bmft_pkg::PH_IDLE;
      tick_left_r  <= '0;
      bit_index_r  <= '0;
      frame_byte_r <= '0;
      parity_r     <= 1'b0;
      pin_r        <= 1'b0;
      pend_r       <= 1'b0;
      pend_byte_r  <= '0;
    end else if (cmd_pop) begin
      phase_r      <= phase_nxt;
      tick_left_r  <= tick_left_nxt;
      bit_index_r  <= bit_index_nxt;
      frame_byte_r <= frame_byte_nxt;
      parity_r     <= parity_nxt;
      pin_r        <= pin_nxt;
      pend_r       <= pend_nxt;
      pend_byte_r  <= pend_byte_nxt;
    end
  end

  bmft_queue #(
    .WIDTH ($bits(bmft_pkg::res_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_pop),
    .wdata (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_bits),
    .empty (out_empty)
  );

  assign res = bmft_pkg::res_t'(res_bits);

endmodule

// ===== design/biphase_mark_frame_transmitter.sv =====
// ---------------------------------------------------------------------------
// Biphase-mark frame transmitter
// Sends the low DATA_BITS bits of a byte as a biphase-mark frame, one line
// level per half-bit tick word.
// Input words: push/full with in_opcode (0 send request, 1 tick) and
// in_send_data. Result words: empty/pop with out_line_level, out_busy_res
// and out_request_pending, one result word per input word, in order.
// An accepted word is registered in the command queue, then its result in
// the result queue. Throughput: one word per cycle while the result queue
// has room, set by the frame state machine, which updates once per command.
// A two-word command queue and a two-word result queue part the sides; when
// the receiver stalls the result queue fills, the state machine holds, then
// the command queue fills and full rises.
// Reset (rst_n low, synchronous) empties both queues, idles the frame
// machine, clears the request slot and drives the line low.
// ---------------------------------------------------------------------------
module biphase_mark_frame_transmitter #(
  parameter int DATA_BITS = 6
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic       in_opcode,
  input  logic [7:0] in_send_data,
  output logic       out_empty,
  input  logic       out_pop,
  output logic       out_line_level,
  output logic       out_busy_res,
  output logic       out_request_pending
);

  logic           cmd_valid;
  logic           cmd_pop;
  bmft_pkg::cmd_t cmd;
  bmft_pkg::res_t res;

  bmft_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_opcode    (in_opcode),
    .in_send_data (in_send_data),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  bmft_back #(
    .DATA_BITS (DATA_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .res       (res)
  );

  assign out_line_level      = res.line_level;
  assign out_busy_res        = res.busy;
  assign out_request_pending = res.pending;

endmodule

// ===== design/bmft_checker.sv =====
// ---------------------------------------------------------------------------
// Biphase-mark frame transmitter checker
// Port-level properties, bound to the top level.
// ---------------------------------------------------------------------------
`include "biphase_mark_frame_transmitter_defines.svh"

module bmft_checker (
  input logic clk,
  input logic rst_n,
  input logic in_push,
  input logic in_full,
  input logic out_empty,
  input logic out_pop,
  input logic out_line_level,
  input logic out_busy_res,
  input logic out_request_pending
);

  logic [2:0] out_word;

  assign out_word = {out_line_level, out_busy_res, out_request_pending};

  `BMFT_ASSERT_NEXT(a_out_hold, !out_empty && !out_pop, !out_empty && $stable(out_word))

  `BMFT_ASSERT_NOW(a_pend_busy, !out_empty && out_request_pending, out_busy_res)

  `BMFT_ASSERT_NOW(a_idle_low, !out_empty && !out_busy_res, !out_line_level)

  `BMFT_ASSERT_NOW(a_full_cause, $rose(in_full), $past(in_push))

endmodule

bind biphase_mark_frame_transmitter bmft_checker u_bmft_checker (.*);
